### sv/jacobi_laplace_grid_solver_assert.svh
// Assertion helpers shared by the solver RTL.
`ifndef JACOBI_LAPLACE_GRID_SOLVER_ASSERT_SVH
`define JACOBI_LAPLACE_GRID_SOLVER_ASSERT_SVH

// same-cycle implication
`define JLGS_ASSERT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JLGS_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

### sv/jlgs_pkg.sv
package jlgs_pkg;

  localparam int GRID_SIZE = 4;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;
  localparam int IDXW      = $clog2(GRID_SIZE);
  localparam int CW        = $clog2(CELLS);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_RUN   = 1'b1;

  localparam logic REG_ITER_COUNT = 1'b0;  // register index, paddr[2]

  typedef struct packed {
    logic               func;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] cell_value;
  } jlgs_in_t;

  typedef struct packed {
    logic [1:0]         out_row;
    logic [1:0]         out_col;
    logic signed [31:0] out_value;
    logic               last;
  } jlgs_out_t;

endpackage

### sv/jacobi_laplace_grid_solver.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_stall_o jlgs_in_t  (func, row, col, cell_value)
// out       output     out_valid_o/out_stall_i jlgs_out_t (out_row, out_col, out_value, last)
// cfg       APB slave  psel/penable/pready   iteration_count at byte address 0
//
// In a run, each interior cell of a sweep steps through ST_RD0 and ST_RD1 (two dual-port
// memory reads), then ST_WR (the sum and write back); emission then reads and emits
// one cell at a time, holding while the output is stalled.
// Grid and working copy are two 2-read/1-write banks, swapped after every sweep but the first.
// Reset clears control and per-cell valid bits; an unwritten cell reads as zero.
// Output stall only holds the emitter; sweeps never wait on the output side.
module jacobi_laplace_grid_solver (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  jlgs_pkg::jlgs_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output jlgs_pkg::jlgs_out_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import jlgs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_WR,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [15:0]       iter_q;
  logic [15:0]       sweep_cnt_q;
  logic [CW-1:0]     cell_q;
  logic [IDXW-1:0]   row_q;
  logic [IDXW-1:0]   col_q;
  logic              cur_q;
  logic [CELLS-1:0]  vld_q;
  logic [32:0]       part_q;
  logic [CW-1:0]     emit_cell_q;
  logic [IDXW-1:0]   emit_row_q;
  logic [IDXW-1:0]   emit_col_q;
  logic              rd_ok_q;
  logic              out_vld_q;
  jlgs_out_t         out_q;

  logic [31:0]       mem0 [CELLS];
  logic [31:0]       mem1 [CELLS];
  logic [31:0]       rd0a_q, rd0b_q, rd1a_q, rd1b_q;
  logic              rvlda_q, rvldb_q;

  logic              in_acc, out_acc, cfg_wr;
  logic              first, diag, in_range, load, last_col, last_row;
  logic [CW-1:0]     raddr_a, raddr_b, waddr, wr_cell;
  logic              wen0, wen1;
  logic [31:0]       wdata, va, vb, avg;
  logic [33:0]       sum;

  localparam logic [IDXW-1:0] LastInt = IDXW'(GRID_SIZE - 2);
  localparam logic [CW-1:0]   FirstCell = CW'(GRID_SIZE + 1);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign out_acc     = out_vld_q && !out_stall_i;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ITER_COUNT);
  assign prdata = (paddr[2] == REG_ITER_COUNT) ? {16'd0, iter_q} : 32'd0;

  assign first    = (sweep_cnt_q == 16'd0);
  assign diag     = first && (cell_q == FirstCell);
  assign last_col = (col_q == LastInt);
  assign last_row = (row_q == LastInt);
  assign in_range = (32'(in_data_i.row) < GRID_SIZE) && (32'(in_data_i.col) < GRID_SIZE);
  assign wr_cell  = CW'(32'(in_data_i.row) * GRID_SIZE + 32'(in_data_i.col));
  assign load     = (state_q == ST_EMIT) && rd_ok_q && (!out_vld_q || !out_stall_i);

  // neighbor addresses: RD0 fetches the first pair, RD1 the second
  always_comb begin
    raddr_a = emit_cell_q;
    raddr_b = emit_cell_q;
    if (state_q == ST_RD0) begin
      raddr_a = diag ? cell_q - CW'(GRID_SIZE + 1) : cell_q + CW'(GRID_SIZE);
      raddr_b = diag ? cell_q - CW'(GRID_SIZE - 1) : cell_q - CW'(GRID_SIZE);
    end else if (state_q == ST_RD1) begin
      raddr_a = diag ? cell_q + CW'(GRID_SIZE - 1) : cell_q + CW'(1);
      raddr_b = diag ? cell_q + CW'(GRID_SIZE + 1) : cell_q - CW'(1);
    end
  end

  assign va  = rvlda_q ? (cur_q ? rd1a_q : rd0a_q) : 32'd0;
  assign vb  = rvldb_q ? (cur_q ? rd1b_q : rd0b_q) : 32'd0;
  assign sum = {part_q[32], part_q} + {{2{va[31]}}, va} + {{2{vb[31]}}, vb};
  assign avg = sum[33:2];  // floor division by four

  // first sweep updates in place, later sweeps write the other bank
  always_comb begin
    wen0  = 1'b0;
    wen1  = 1'b0;
    waddr = cell_q;
    wdata = avg;
    if (state_q == ST_WR) begin
      wen0 = ((first ? cur_q : !cur_q) == 1'b0);
      wen1 = !wen0;
    end else if (in_acc && in_data_i.func == FUNC_WRITE && in_range) begin
      wen0  = 1'b1;
      wen1  = 1'b1;
      waddr = wr_cell;
      wdata = in_data_i.cell_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen0) mem0[waddr] <= wdata;
    if (wen1) mem1[waddr] <= wdata;
    rd0a_q <= mem0[raddr_a];
    rd0b_q <= mem0[raddr_b];
    rd1a_q <= mem1[raddr_a];
    rd1b_q <= mem1[raddr_b];
    part_q <= {va[31], va} + {vb[31], vb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= 16'd1;
      sweep_cnt_q <= '0;
      cell_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      cur_q       <= 1'b0;
      vld_q       <= '0;
      rvlda_q     <= 1'b0;
      rvldb_q     <= 1'b0;
      emit_cell_q <= '0;
      emit_row_q  <= '0;
      emit_col_q  <= '0;
      rd_ok_q     <= 1'b0;
      out_vld_q   <= 1'b0;
      out_q       <= '0;
    end else begin
      rvlda_q <= vld_q[raddr_a];
      rvldb_q <= vld_q[raddr_b];
      if (cfg_wr) iter_q <= pwdata[15:0];
      if (wen0 || wen1) vld_q[waddr] <= 1'b1;
      if (out_acc && !load) out_vld_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && in_data_i.func == FUNC_RUN) begin
            sweep_cnt_q <= '0;
            cell_q      <= FirstCell;
            row_q       <= IDXW'(1);
            col_q       <= IDXW'(1);
            emit_cell_q <= '0;
            emit_row_q  <= '0;
            emit_col_q  <= '0;
            rd_ok_q     <= 1'b0;
            state_q     <= (iter_q == 16'd0) ? ST_EMIT : ST_RD0;
          end
        end
        ST_RD0: state_q <= ST_RD1;
        ST_RD1: state_q <= ST_WR;
        ST_WR: begin
          state_q <= (last_col && last_row && ((sweep_cnt_q + 16'd1) == iter_q)) ?
                     ST_EMIT : ST_RD0;
          if (!last_col) begin
            col_q  <= col_q + IDXW'(1);
            cell_q <= cell_q + CW'(1);
          end else if (!last_row) begin
            row_q  <= row_q + IDXW'(1);
            col_q  <= IDXW'(1);
            cell_q <= cell_q + CW'(3);
          end else begin
            // sweep done
            if (!first) cur_q <= !cur_q;
            sweep_cnt_q <= sweep_cnt_q + 16'd1;
            cell_q      <= FirstCell;
            row_q       <= IDXW'(1);
            col_q       <= IDXW'(1);
          end
        end
        ST_EMIT: begin
          rd_ok_q <= !load;
          if (load) begin
            out_vld_q         <= 1'b1;
            out_q.out_row     <= 2'(emit_row_q);
            out_q.out_col     <= 2'(emit_col_q);
            out_q.out_value   <= va;
            out_q.last        <= (emit_cell_q == CW'(CELLS - 1));
            emit_cell_q       <= emit_cell_q + CW'(1);
            if (emit_col_q == IDXW'(GRID_SIZE - 1)) begin
              emit_col_q <= '0;
              emit_row_q <= emit_row_q + IDXW'(1);
            end else begin
              emit_col_q <= emit_col_q + IDXW'(1);
            end
            if (emit_cell_q == CW'(CELLS - 1)) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`include "jacobi_laplace_grid_solver_assert.svh"

  `JLGS_ASSERT_NEXT(a_no_result_after_last, out_acc && out_q.last,
                    !out_valid_o || !out_q.last, "result after last cell")
  `JLGS_ASSERT(a_wr_interior_only, state_q == ST_WR,
               (row_q != '0) && (col_q != '0) && !(row_q > LastInt) && !(col_q > LastInt),
               "sweep wrote a boundary cell")
  `JLGS_ASSERT_NEXT(a_run_stalls_input, in_acc && in_data_i.func == FUNC_RUN,
                    in_stall_o, "input taken during run")
  `JLGS_ASSERT(a_rd_ok_in_emit, rd_ok_q, state_q == ST_EMIT, "emit read flag outside emission")

endmodule

### test/tb_jacobi_laplace_grid_solver.sv
module tb_jacobi_laplace_grid_solver;
  timeunit 1ns;
  timeprecision 1ps;

  import jlgs_pkg::*;

  localparam int       CYCLE_LIMIT  = 10_000_000;
  localparam int       TOTAL_ITEMS  = 410;
  localparam int       BATCH_ITEMS  = 33;
  localparam int       SETTLE       = 16;
  localparam logic [2:0] ITER_ADDR  = {REG_ITER_COUNT, 2'b00};

  class grid_scoreboard;
    logic signed [31:0] cells [CELLS];
    logic [15:0]        iterations;
    jlgs_out_t          pending [$];
    int                 mismatches;
    int                 cells_checked;
    int                 runs;

    function new();
      foreach (cells[k]) cells[k] = '0;
      iterations    = 16'd1;
      mismatches    = 0;
      cells_checked = 0;
      runs          = 0;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
    endtask

    // floor of the four-term mean; 34 bits hold the sum exactly
    function logic signed [31:0] quarter_sum(logic signed [31:0] a, logic signed [31:0] b,
                                             logic signed [31:0] c, logic signed [31:0] d);
      logic signed [33:0] total;
      total = a + b + c + d;
      return total[33:2];
    endfunction

    // First sweep: (1,1) from its diagonals, then Gauss-Seidel over the interior.
    // Later sweeps: plain Jacobi from the previous grid.
    function void relax(bit first);
      logic signed [31:0] upd [CELLS];
      int k;
      upd = cells;
      if (first)
        upd[GRID_SIZE+1] = quarter_sum(cells[0], cells[2], cells[2*GRID_SIZE],
                                       cells[2*GRID_SIZE+2]);
      for (int r = 1; r < GRID_SIZE - 1; r++) begin
        for (int c = 1; c < GRID_SIZE - 1; c++) begin
          k = r * GRID_SIZE + c;
          if (first && k == GRID_SIZE + 1) continue;
          if (first)
            upd[k] = quarter_sum(upd[k+GRID_SIZE], upd[k-GRID_SIZE], upd[k+1], upd[k-1]);
          else
            upd[k] = quarter_sum(cells[k+GRID_SIZE], cells[k-GRID_SIZE], cells[k+1],
                                 cells[k-1]);
        end
      end
      cells = upd;
    endfunction

    function void note_request(jlgs_in_t req);
      jlgs_out_t exp;
      if (req.func == FUNC_WRITE) begin
        cells[int'(req.row) * GRID_SIZE + int'(req.col)] = req.cell_value;
        return;
      end
      runs++;
      for (int s = 0; s < int'(iterations); s++) relax(s == 0);
      for (int k = 0; k < CELLS; k++) begin
        exp.out_row   = 2'((k / GRID_SIZE) & 3);
        exp.out_col   = 2'((k % GRID_SIZE) & 3);
        exp.out_value = cells[k];
        exp.last      = (k == CELLS - 1);
        pending.push_back(exp);
      end
    endfunction

    task check_result(jlgs_out_t got);
      jlgs_out_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected cell (%0d,%0d) value %h", got.out_row, got.out_col,
                         got.out_value));
        return;
      end
      exp = pending.pop_front();
      cells_checked++;
      if (got.out_row !== exp.out_row)
        report($sformatf("out_row %0d, want %0d", got.out_row, exp.out_row));
      if (got.out_col !== exp.out_col)
        report($sformatf("out_col %0d, want %0d", got.out_col, exp.out_col));
      if (got.out_value !== exp.out_value)
        report($sformatf("cell (%0d,%0d) value %h, want %h", exp.out_row, exp.out_col,
                         got.out_value, exp.out_value));
      if (got.last !== exp.last)
        report($sformatf("cell (%0d,%0d) last %b, want %b", exp.out_row, exp.out_col,
                         got.last, exp.last));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  jlgs_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  jlgs_out_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  grid_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent  = 0;
  int settings    = 0;
  int cycles      = 0;

  jacobi_laplace_grid_solver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d cells still pending", cycles,
               sb.pending.size());
      $display("FAIL jacobi_laplace_grid_solver");
      $finish;
    end
  end

  // result side: check at the edge, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    out_stall_i <= (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);
  end

  // valid stays high across back-to-back requests; caller lowers it when done
  task send_request(jlgs_in_t req);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
    items_sent++;
  endtask

  task drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task program_iterations(logic [15:0] n);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ITER_ADDR;
    pwdata  <= {16'd0, n};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== n)
      sb.report($sformatf("iteration_count reads %h, want %h", prdata[15:0], n));
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.iterations = n;
    settings++;
  endtask

  function jlgs_in_t cell_write(int r, int c, logic [31:0] v);
    jlgs_in_t req;
    req.func       = FUNC_WRITE;
    req.row        = 2'(r);
    req.col        = 2'(c);
    req.cell_value = v;
    return req;
  endfunction

  // run request with junk in the ignored fields
  function jlgs_in_t run_request();
    jlgs_in_t req;
    req.func       = FUNC_RUN;
    req.row        = 2'($urandom_range(3));
    req.col        = 2'($urandom_range(3));
    req.cell_value = $urandom;
    return req;
  endfunction

  function jlgs_in_t random_write();
    logic [31:0] v;
    case ($urandom_range(9))
      0:       v = 32'h7fff_ffff;
      1:       v = 32'h8000_0000;
      2:       v = 32'($urandom_range(32'h3ffff));
      3:       v = -32'($urandom_range(32'h3ffff));
      default: v = $urandom;
    endcase
    return cell_write($urandom_range(3), $urandom_range(3), v);
  endfunction

  function logic [15:0] random_iterations();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'($urandom_range(50, 300));
      default: return 16'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    int quota;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    rst_ni      <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset grid, reset sweep count of one
    send_request(run_request());
    // extremes on the boundary and on the diagonal taps of (1,1)
    send_request(cell_write(0, 0, 32'h7fff_ffff));
    send_request(cell_write(0, 2, 32'h7fff_ffff));
    send_request(cell_write(2, 0, 32'h8000_0000));
    send_request(cell_write(2, 2, 32'h7fff_ffff));
    send_request(cell_write(0, 1, 32'h8000_0000));
    send_request(cell_write(1, 0, 32'h8000_0000));
    send_request(cell_write(0, 3, 32'hffff_ffff));
    send_request(cell_write(3, 0, 32'h0000_0001));
    send_request(cell_write(3, 3, 32'h7fff_ffff));
    send_request(cell_write(1, 3, 32'h8000_0000));
    send_request(cell_write(3, 2, 32'h8000_0000));
    send_request(run_request());
    drain();
    // zero sweeps emits the grid untouched
    program_iterations(16'd0);
    send_request(run_request());
    drain();
    program_iterations(16'd2);
    send_request(cell_write(2, 3, 32'hfffe_0000));
    send_request(cell_write(3, 1, 32'h0001_8000));
    send_request(run_request());
    drain();
    program_iterations(16'hffff);
    send_request(run_request());

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 56 : 0;
      rx_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 34 : 0;
      for (int b = 0; b < 4; b++) begin
        drain();
        program_iterations(random_iterations());
        quota = items_sent + BATCH_ITEMS;
        while (items_sent < quota && items_sent < TOTAL_ITEMS) begin
          repeat ($urandom_range(1, 9)) send_request(random_write());
          send_request(run_request());
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests, %0d of them runs, over %0d sweep-count settings;",
             items_sent, sb.runs, settings);
    $display("checked %0d emitted cells, %0d mismatches.", sb.cells_checked,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("PASS jacobi_laplace_grid_solver");
    else
      $display("FAIL jacobi_laplace_grid_solver");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/jlgs_pkg.sv
sv/jacobi_laplace_grid_solver.sv
test/tb_jacobi_laplace_grid_solver.sv
